[hdl/tle_pkg.sv]
// Shared constants, enums and transaction types for the terminal line editor.
`default_nettype none

package tle_pkg;

  // Line buffer capacity (8..64) and the widths that follow from it
  localparam int unsigned LineCapacity = 64;
  localparam int unsigned AddrW        = $clog2(LineCapacity);
  localparam int unsigned LenW         = $clog2(LineCapacity + 1);

  // Console byte codes
  localparam logic [7:0] ChrBs     = 8'h08;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrEsc    = 8'h1B;
  localparam logic [7:0] ChrBsl    = 8'h5C;
  localparam logic [7:0] ChrSq     = 8'h27;
  localparam logic [7:0] ChrDq     = 8'h22;
  localparam logic [7:0] ChrLbrack = 8'h5B;
  localparam logic [7:0] ChrLeft   = 8'h44;
  localparam logic [7:0] ChrRight  = 8'h43;
  localparam logic [7:0] ChrHome   = 8'h48;
  localparam logic [7:0] ChrEnd    = 8'h46;
  localparam logic [7:0] ChrPrMin  = 8'd32;
  localparam logic [7:0] ChrPrMax  = 8'd126;

  // Escape prefix held between bytes
  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_BSL  = 2'd1,
    PFX_ESC  = 2'd2,
    PFX_CSI  = 2'd3
  } prefix_e;

  // Class of a byte with no prefix pending
  typedef enum logic [2:0] {
    CLS_BS,
    CLS_ESC,
    CLS_BSL,
    CLS_SQ,
    CLS_DQ,
    CLS_PRINT,
    CLS_TAB,
    CLS_OTHER
  } byte_class_e;

  // Meaning of a byte following ESC [
  typedef enum logic [2:0] {
    CSI_LEFT,
    CSI_RIGHT,
    CSI_HOME,
    CSI_END,
    CSI_NONE
  } csi_e;

  // Port transactions
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_char;
    logic       overflowed;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic        eol;
    logic [7:0]  data;
    byte_class_e cls;
    csi_e        csi;
    logic        lbrack;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/tle_front.sv]
// Front end: accepts console transactions, classifies them, queues them for the back end.
`default_nettype none

module tle_front
  import tle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_take_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_new;
  logic       accept;
  logic       take;

  // Byte classification
  always_comb begin
    cmd_new.eol    = in_item_i.req_type;
    cmd_new.data   = in_item_i.in_byte;
    cmd_new.lbrack = (in_item_i.in_byte == ChrLbrack);
    priority if (in_item_i.in_byte == ChrBs)  cmd_new.cls = CLS_BS;
    else if (in_item_i.in_byte == ChrEsc)     cmd_new.cls = CLS_ESC;
    else if (in_item_i.in_byte == ChrBsl)     cmd_new.cls = CLS_BSL;
    else if (in_item_i.in_byte == ChrSq)      cmd_new.cls = CLS_SQ;
    else if (in_item_i.in_byte == ChrDq)      cmd_new.cls = CLS_DQ;
    else if (in_item_i.in_byte >= ChrPrMin &&
             in_item_i.in_byte <= ChrPrMax)   cmd_new.cls = CLS_PRINT;
    else if (in_item_i.in_byte == ChrTab)     cmd_new.cls = CLS_TAB;
    else                                      cmd_new.cls = CLS_OTHER;
    priority if (in_item_i.in_byte == ChrLeft) cmd_new.csi = CSI_LEFT;
    else if (in_item_i.in_byte == ChrRight)    cmd_new.csi = CSI_RIGHT;
    else if (in_item_i.in_byte == ChrHome)     cmd_new.csi = CSI_HOME;
    else if (in_item_i.in_byte == ChrEnd)      cmd_new.csi = CSI_END;
    else                                       cmd_new.csi = CSI_NONE;
  end

  // Two-entry command queue
  assign full        = (count_q == 2'd2);
  assign accept      = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign take        = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, accept} - {1'b0, take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

[hdl/tle_back.sv]
// Back end: line memory, cursor editing sequencer and result output register.
`default_nettype none

module tle_back
  import tle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_take_o,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_item_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StInsShift = 3'd1;
  localparam logic [2:0] StInsPut   = 3'd2;
  localparam logic [2:0] StDelShift = 3'd3;
  localparam logic [2:0] StEmitRd   = 3'd4;
  localparam logic [2:0] StEmitWr   = 3'd5;

  localparam logic [LenW-1:0] CapLen = LenW'(LineCapacity);

  logic [2:0]       state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  cur_q, cur_d;
  logic             sq_q, sq_d;
  logic             dq_q, dq_d;
  prefix_e          pfx_q, pfx_d;
  logic             ovf_q, ovf_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [7:0]       ins_char_q, ins_char_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic [7:0]       mem_q [LineCapacity];
  logic [7:0]       rdata_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [AddrW-1:0] rd_addr;

  logic             do_ins;
  logic [7:0]       ins_byte;
  logic             do_del;
  logic             slot_free;
  logic             out_load;
  logic             line_done;
  logic [AddrW-1:0] cur_addr;
  logic [AddrW-1:0] len_addr;

  assign slot_free  = !out_valid_q || pop;
  assign cur_addr   = cur_q[AddrW-1:0];
  assign len_addr   = len_q[AddrW-1:0];
  assign empty      = !out_valid_q;
  assign out_item_o = out_item_q;

  // Editing sequencer
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    cur_d      = cur_q;
    sq_d       = sq_q;
    dq_d       = dq_q;
    pfx_d      = pfx_q;
    ovf_d      = ovf_q;
    ptr_d      = ptr_q;
    ins_char_d = ins_char_q;
    cmd_take_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ptr_q;
    wr_data    = rdata_q;
    rd_addr    = ptr_q;
    do_ins     = 1'b0;
    ins_byte   = cmd_i.data;
    do_del     = 1'b0;
    out_load   = 1'b0;
    line_done  = 1'b0;
    out_item_d = out_item_q;

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          if (cmd_i.eol) begin
            // pending backslash or ESC [ is flushed first, then the item reruns
            priority case (pfx_q)
              PFX_BSL: begin
                do_ins   = 1'b1;
                ins_byte = ChrBsl;
                pfx_d    = PFX_NONE;
              end
              PFX_CSI: begin
                do_ins   = 1'b1;
                ins_byte = ChrLbrack;
                pfx_d    = PFX_NONE;
              end
              default: begin
                cmd_take_o = 1'b1;
                pfx_d      = PFX_NONE;
                ptr_d      = '0;
                state_d    = StEmitRd;
              end
            endcase
          end else begin
            unique case (pfx_q)
              PFX_BSL: begin
                cmd_take_o = 1'b1;
                pfx_d      = PFX_NONE;
                do_ins     = 1'b1;
              end
              PFX_ESC: begin
                // without '[' the ESC is dropped and the byte reruns plainly
                if (cmd_i.lbrack) begin
                  cmd_take_o = 1'b1;
                  pfx_d      = PFX_CSI;
                end else begin
                  pfx_d = PFX_NONE;
                end
              end
              PFX_CSI: begin
                pfx_d = PFX_NONE;
                unique case (cmd_i.csi)
                  CSI_LEFT: begin
                    cmd_take_o = 1'b1;
                    if (cur_q != '0) cur_d = cur_q - 1'b1;
                  end
                  CSI_RIGHT: begin
                    cmd_take_o = 1'b1;
                    if (cur_q != len_q) cur_d = cur_q + 1'b1;
                  end
                  CSI_HOME: begin
                    cmd_take_o = 1'b1;
                    cur_d      = '0;
                  end
                  CSI_END: begin
                    cmd_take_o = 1'b1;
                    cur_d      = len_q;
                  end
                  default: begin
                    // insert '[' and rerun the byte plainly
                    do_ins   = 1'b1;
                    ins_byte = ChrLbrack;
                  end
                endcase
              end
              default: begin
                cmd_take_o = 1'b1;
                unique case (cmd_i.cls)
                  CLS_BS:    do_del = 1'b1;
                  CLS_ESC:   pfx_d  = PFX_ESC;
                  CLS_BSL:   pfx_d  = PFX_BSL;
                  CLS_SQ: begin
                    if (!dq_q) sq_d = !sq_q;
                    do_ins = 1'b1;
                  end
                  CLS_DQ: begin
                    if (!sq_q) dq_d = !dq_q;
                    do_ins = 1'b1;
                  end
                  CLS_PRINT: do_ins = 1'b1;
                  CLS_TAB:   do_ins = sq_q || dq_q;
                  default:   do_ins = 1'b0;
                endcase
              end
            endcase
          end

          // insert start: overflow flag if full, direct write at the end, else shift up from the tail
          if (do_ins) begin
            ins_char_d = ins_byte;
            if (len_q == CapLen) begin
              ovf_d = 1'b1;
            end else if (cur_q == len_q) begin
              wr_en   = 1'b1;
              wr_addr = cur_addr;
              wr_data = ins_byte;
              len_d   = len_q + 1'b1;
              cur_d   = cur_q + 1'b1;
            end else begin
              rd_addr = len_addr - 1'b1;
              ptr_d   = len_addr;
              state_d = StInsShift;
            end
          end

          // delete start: drop the tail byte, else shift down from the cursor
          if (do_del && cur_q != '0) begin
            if (cur_q == len_q) begin
              len_d = len_q - 1'b1;
              cur_d = cur_q - 1'b1;
            end else begin
              rd_addr = cur_addr;
              ptr_d   = cur_addr - 1'b1;
              state_d = StDelShift;
            end
          end
        end
      end

      StInsShift: begin
        // rdata_q holds entry ptr-1; move it to ptr
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = rdata_q;
        if (ptr_q - 1'b1 == cur_addr) begin
          state_d = StInsPut;
        end else begin
          rd_addr = ptr_q - AddrW'(2);
          ptr_d   = ptr_q - 1'b1;
        end
      end

      StInsPut: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = ins_char_q;
        len_d   = len_q + 1'b1;
        cur_d   = cur_q + 1'b1;
        state_d = StIdle;
      end

      StDelShift: begin
        // rdata_q holds entry ptr+1; move it to ptr
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = rdata_q;
        if (LenW'(ptr_q) + LenW'(2) < len_q) begin
          rd_addr = ptr_q + AddrW'(2);
          ptr_d   = ptr_q + 1'b1;
        end else begin
          len_d   = len_q - 1'b1;
          cur_d   = cur_q - 1'b1;
          state_d = StIdle;
        end
      end

      StEmitRd: begin
        rd_addr = ptr_q;
        state_d = StEmitWr;
      end

      StEmitWr: begin
        rd_addr = ptr_q;
        if (slot_free) begin
          out_load = 1'b1;
          if (len_q == '0) begin
            out_item_d = '{out_char: 8'h00, char_valid: 1'b0, last_char: 1'b1,
                           overflowed: ovf_q};
            line_done  = 1'b1;
          end else begin
            out_item_d.out_char   = rdata_q;
            out_item_d.char_valid = 1'b1;
            out_item_d.last_char  = (LenW'(ptr_q) + 1'b1 == len_q);
            out_item_d.overflowed = ovf_q;
            if (LenW'(ptr_q) + 1'b1 == len_q) begin
              line_done = 1'b1;
            end else begin
              rd_addr = ptr_q + 1'b1;
              ptr_d   = ptr_q + 1'b1;
            end
          end
        end
      end

      default: state_d = StIdle;
    endcase

    // end of line returns the editor to its reset state
    if (line_done) begin
      len_d   = '0;
      cur_d   = '0;
      sq_d    = 1'b0;
      dq_d    = 1'b0;
      pfx_d   = PFX_NONE;
      ovf_d   = 1'b0;
      state_d = StIdle;
    end

    // output register
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      cur_q       <= '0;
      sq_q        <= 1'b0;
      dq_q        <= 1'b0;
      pfx_q       <= PFX_NONE;
      ovf_q       <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      sq_q        <= sq_d;
      dq_q        <= dq_d;
      pfx_q       <= pfx_d;
      ovf_q       <= ovf_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ins_char_q <= ins_char_d;
    out_item_q <= out_item_d;
  end

  // line memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/terminal_line_editor.sv]
// Top level of the terminal line editor: front classifier queue feeding the edit engine.
`default_nettype none

// Console bytes are pushed in as transactions and edited into a line buffer
// of LineCapacity bytes at a cursor; an end-of-line transaction pops the
// cleaned line out one byte per result (a single invalid result for an empty
// line). A two-entry command queue decouples input from the edit engine, and
// a result register decouples the engine from the reader. Cursor moves,
// prefix bytes, dropped bytes, and inserts or backspaces at the line end are
// handled directly in the engine's idle state. An unmatched ESC is dropped and
// an unmatched ESC [ inserts its '[' before the byte after it is handled. An
// insert in the middle of the line shifts the tail up through the line memory,
// one entry per cycle, and a backspace in the middle shifts it down the same
// way. End of line first inserts a pending backslash or ESC [, then emits the
// line, waiting whenever the reader has not yet taken the last result.
module terminal_line_editor
  import tle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  tle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  tle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
